// File: design/wfrc_pkg.sv
package wfrc_pkg;

    localparam int unsigned NUM_RULES_DEF = 16;
    localparam int unsigned SLOT_W = 4;
    localparam int unsigned SLOT_RANGE = 1 << SLOT_W;
    localparam int unsigned MAC_W = 48;
    localparam int unsigned IP_W = 32;
    localparam int unsigned PORT_W = 16;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [IP_W-1:0]   src_ip;
        logic [IP_W-1:0]   dst_ip;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
    } flow_t;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } action_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic              valid;
        flow_t             keys;
        action_t           act;
    } rule_wr_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        action_t           act;
    } scan_res_t;

    function automatic logic key_ok(input flow_t key, input flow_t val);
        logic ok;
        ok = ((key.src_mac == '0) || (key.src_mac == val.src_mac))
            && ((key.dst_mac == '0) || (key.dst_mac == val.dst_mac))
            && ((key.src_ip == '0) || (key.src_ip == val.src_ip))
            && ((key.dst_ip == '0) || (key.dst_ip == val.dst_ip))
            && ((key.src_port == '0) || (key.src_port == val.src_port))
            && ((key.dst_port == '0) || (key.dst_port == val.dst_port));
        return ok;
    endfunction

endpackage

// File: design/wfrc_cell.sv
module wfrc_cell
    import wfrc_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  rule_wr_t  wr,
    input  logic      in_valid,
    input  flow_t     in_flow,
    input  scan_res_t in_res,
    output logic      out_valid,
    output flow_t     out_flow,
    output scan_res_t out_res
);

    logic      entry_valid_reg;
    flow_t     key_reg;
    action_t   act_reg;
    logic      tok_valid_reg;
    flow_t     flow_reg;
    scan_res_t res_reg;
    scan_res_t res_next;
    logic      wr_here;

    assign wr_here = wr.en && (CELL_IDX < SLOT_RANGE) && (wr.slot == SLOT_W'(CELL_IDX));

    always_comb
    begin
        res_next = in_res;
        if (!in_res.done)
        begin
            if (!entry_valid_reg)
            begin
                res_next.done = 1'b1;
            end
            else if (key_ok(key_reg, in_flow))
            begin
                res_next.done = 1'b1;
                res_next.hit  = 1'b1;
                res_next.slot = SLOT_W'(CELL_IDX);
                res_next.act  = act_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            tok_valid_reg   <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= in_valid;
            if (wr_here)
            begin
                entry_valid_reg <= wr.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            key_reg <= wr.keys;
            act_reg <= wr.act;
        end
        flow_reg <= in_flow;
        res_reg  <= res_next;
    end

    assign out_valid = tok_valid_reg;
    assign out_flow  = flow_reg;
    assign out_res   = res_reg;

endmodule

// File: design/wildcard_flow_rule_classifier_unit.sv
// Channel  Ports                                         Handshake
// -------  --------------------------------------------  ---------------------------
// input    cmd rule_slot slot_valid src_mac dst_mac      start high, busy low
//          src_ip dst_ip src_port dst_port new_*
// result   hit hit_slot out_mac out_ip out_port          done high for one cycle
//
// A rule write leaves busy low, so the next transfer can follow at once.
// A lookup walks the row of rule cells one cell per cycle, so its result passes through the
// register of every cell before it appears, and busy stays high until the cycle after done.
// Reset clears every valid flag and the lookup token, and the receiver cannot stall results.
module wildcard_flow_rule_classifier_unit
    import wfrc_pkg::*;
#(
    parameter int unsigned NUM_RULES = NUM_RULES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [SLOT_W-1:0] rule_slot,
    input  logic              slot_valid,
    input  logic [MAC_W-1:0]  src_mac,
    input  logic [MAC_W-1:0]  dst_mac,
    input  logic [IP_W-1:0]   src_ip,
    input  logic [IP_W-1:0]   dst_ip,
    input  logic [PORT_W-1:0] src_port,
    input  logic [PORT_W-1:0] dst_port,
    input  logic [MAC_W-1:0]  new_mac,
    input  logic [IP_W-1:0]   new_ip,
    input  logic [PORT_W-1:0] new_port,
    output logic              done,
    output logic              hit,
    output logic [SLOT_W-1:0] hit_slot,
    output logic [MAC_W-1:0]  out_mac,
    output logic [IP_W-1:0]   out_ip,
    output logic [PORT_W-1:0] out_port
);

    logic      busy_reg;
    logic      busy_next;
    logic      accept;
    flow_t     in_flow;
    rule_wr_t  wr;
    logic      chain_valid [NUM_RULES+1];
    flow_t     chain_flow [NUM_RULES+1];
    scan_res_t chain_res [NUM_RULES+1];
    logic [NUM_RULES-1:0] tok_vec;

    assign accept = start && !busy_reg;

    assign in_flow.src_mac  = src_mac;
    assign in_flow.dst_mac  = dst_mac;
    assign in_flow.src_ip   = src_ip;
    assign in_flow.dst_ip   = dst_ip;
    assign in_flow.src_port = src_port;
    assign in_flow.dst_port = dst_port;

    assign wr.en       = accept && (cmd_t'(cmd) == CMD_WRITE);
    assign wr.slot     = rule_slot;
    assign wr.valid    = slot_valid;
    assign wr.keys     = in_flow;
    assign wr.act.mac  = new_mac;
    assign wr.act.ip   = new_ip;
    assign wr.act.port = new_port;

    assign chain_valid[0] = accept && (cmd_t'(cmd) == CMD_LOOKUP);
    assign chain_flow[0]  = in_flow;
    assign chain_res[0]   = '0;

    for (genvar i = 0; i < NUM_RULES; i++)
    begin : g_cell
        wfrc_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .in_valid  (chain_valid[i]),
            .in_flow   (chain_flow[i]),
            .in_res    (chain_res[i]),
            .out_valid (chain_valid[i+1]),
            .out_flow  (chain_flow[i+1]),
            .out_res   (chain_res[i+1])
        );
        assign tok_vec[i] = chain_valid[i+1];
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (chain_valid[0])
        begin
            busy_next = 1'b1;
        end
        else if (chain_valid[NUM_RULES])
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = chain_valid[NUM_RULES];
    assign hit      = chain_res[NUM_RULES].hit;
    assign hit_slot = chain_res[NUM_RULES].slot;
    assign out_mac  = chain_res[NUM_RULES].act.mac;
    assign out_ip   = chain_res[NUM_RULES].act.ip;
    assign out_port = chain_res[NUM_RULES].act.port;

`ifndef SYNTHESIS
    // At most one lookup travels along the row of cells.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_vec) <= 1)
        else $error("more than one lookup in the cell row");

    // A result is only delivered while a lookup is outstanding.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("result without an outstanding lookup");

    // A lookup transfer makes the block busy on the next cycle.
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |=> busy_reg)
        else $error("busy not raised after a lookup transfer");

    // A miss carries all-zero redirect fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (hit_slot == '0 && out_mac == '0 && out_ip == '0
            && out_port == '0))
        else $error("miss with nonzero redirect fields");
`endif

endmodule
